@@ rtl/sensor_compensation_engine_core_defines.svh @@
// Assertion macros shared by the RTL
`ifndef SENSOR_COMPENSATION_ENGINE_CORE_DEFINES_SVH
`define SENSOR_COMPENSATION_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define SCE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define SCE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/sce_pkg.sv @@
package sce_pkg;

    // reading kinds
    localparam logic [1:0] KIND_TEMP  = 2'd0;
    localparam logic [1:0] KIND_PRESS = 2'd1;
    localparam logic [1:0] KIND_HUM   = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_CAL  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESS_A   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESS_B   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESS_C   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HUM_CAL   = 3'd4;

    // compensation constants
    localparam logic [63:0] C_P_FINE_OFS = 64'd128000;
    localparam logic [63:0] C_P_BASE     = 64'd1048576;
    localparam logic [63:0] C_P_SCALE    = 64'd3125;
    localparam logic [63:0] C_P_ONE47    = 64'h0000_8000_0000_0000;
    localparam logic [31:0] C_H_FINE_OFS = 32'd76800;
    localparam logic [31:0] C_H_ROUND_T  = 32'd16384;
    localparam logic [31:0] C_H_Z_OFS    = 32'd2097152;
    localparam logic [31:0] C_H_ROUND_Z  = 32'd8192;
    localparam logic [31:0] C_H_Y_OFS    = 32'd32768;
    localparam logic [31:0] C_H_MAX      = 32'd419430400;
    localparam logic [31:0] C_H_ZERO_SUB = 32'd50000;
    localparam logic [31:0] C_T_ROUND    = 32'd128;

    // input item
    typedef struct packed {
        logic [1:0]  cmd;
        logic [19:0] raw_value;
    } t_in;

    // result item
    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         result_kind;
        logic [1:0]         status;
    } t_out;

    // arithmetic shifts right
    function automatic logic [31:0] f_asr32(input logic [31:0] x, input logic [5:0] sh);
        f_asr32 = $unsigned($signed(x) >>> sh);
    endfunction

    function automatic logic [63:0] f_asr64(input logic [63:0] x, input logic [5:0] sh);
        f_asr64 = $unsigned($signed(x) >>> sh);
    endfunction

endpackage

@@ rtl/sce_mul.sv @@
// 64 x 64 multiplier, low 64 bits of the product, built from one
// 32 x 32 multiplier; o_done pulses when o_prod is valid.
module sce_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_prod
);

    logic        r_busy;
    logic        r_done;
    logic [1:0]  r_step;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_acc;
    logic [31:0] w_x;
    logic [31:0] w_y;
    logic [63:0] w_p;

    // partial product select: lo*lo, lo*hi, hi*lo
    always_comb begin
        w_x = (r_step == 2'd2) ? r_a[63:32] : r_a[31:0];
        w_y = (r_step == 2'd1) ? r_b[63:32] : r_b[31:0];
        w_p = w_x * w_y;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands and accumulator
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end else if (r_busy) begin
            case (r_step)
                2'd0: begin
                    r_acc <= w_p;
                end
                2'd1, 2'd2: begin
                    r_acc <= r_acc + {w_p[31:0], 32'b0};
                end
                default: begin
                    r_acc <= r_acc;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

@@ rtl/sce_div.sv @@
// Signed 64 / 64 divider, truncating, one quotient bit a cycle.
// The divisor must be non-zero; most negative / -1 wraps to most negative.
module sce_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic        r_neg;
    logic [63:0] r_quo;
    logic [63:0] r_den;
    logic [63:0] r_rem;
    logic [64:0] w_sh;
    logic [64:0] w_diff;

    // one restoring step
    always_comb begin
        w_sh   = {r_rem, r_quo[63]};
        w_diff = w_sh - {1'b0, r_den};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // magnitudes and shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[63] ^ i_den[63];
            r_quo <= i_num[63] ? (64'd0 - i_num) : i_num;
            r_den <= i_den[63] ? (64'd0 - i_den) : i_den;
            r_rem <= 64'd0;
        end else if (r_busy) begin
            r_rem <= w_diff[64] ? w_sh[63:0] : w_diff[63:0];
            r_quo <= {r_quo[62:0], ~w_diff[64]};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? (64'd0 - r_quo) : r_quo;

endmodule

@@ rtl/sensor_compensation_engine_core.sv @@
// Sensor compensation engine: takes one raw reading (temperature, pressure or
// humidity) and returns the compensated value from the calibration words in
// the five configuration registers. One item is worked on at a time under a
// sequencer that drives a shared 64-bit multiplier (three 32 x 32 partial
// products) and a bit-serial divider. A pressure reading includes a 64-bit
// division; one whose divisor is zero ends before it with status ST_DIV0.
// o_in_ready is high while the sequencer is idle; a finished result waits in
// the output register and the next reading may be taken meanwhile. A
// temperature reading updates the stored fine temperature used by the two
// other kinds. Write configuration only while no reading is in work.
`include "sensor_compensation_engine_core_defines.svh"

module sensor_compensation_engine_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  sce_pkg::t_in                        i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output sce_pkg::t_out                       o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sce_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [63:0]                         i_cfg_data
);

    typedef enum logic [28:0] {
        S_IDLE    = 29'h0000001,
        S_T_M1    = 29'h0000002,
        S_T_M2    = 29'h0000004,
        S_T_M3    = 29'h0000008,
        S_T_RES   = 29'h0000010,
        S_P_M1    = 29'h0000020,
        S_P_M2    = 29'h0000040,
        S_P_M3    = 29'h0000080,
        S_P_M4    = 29'h0000100,
        S_P_M5    = 29'h0000200,
        S_P_M6    = 29'h0000400,
        S_P_CHK   = 29'h0000800,
        S_P_M7    = 29'h0001000,
        S_P_DIV   = 29'h0002000,
        S_P_M8    = 29'h0004000,
        S_P_M9    = 29'h0008000,
        S_P_M10   = 29'h0010000,
        S_P_SUM   = 29'h0020000,
        S_P_SAT   = 29'h0040000,
        S_H_M1    = 29'h0080000,
        S_H_M2    = 29'h0100000,
        S_H_M3    = 29'h0200000,
        S_H_M4    = 29'h0400000,
        S_H_M5    = 29'h0800000,
        S_H_M6    = 29'h1000000,
        S_H_M7    = 29'h2000000,
        S_H_M8    = 29'h4000000,
        S_H_CLAMP = 29'h8000000,
        S_FIN     = 29'h10000000
    } t_state;

    // calibration registers
    logic [47:0] r_cal_t;
    logic [47:0] r_cal_pa;
    logic [47:0] r_cal_pb;
    logic [47:0] r_cal_pc;
    logic [63:0] r_cal_h;

    // sequencer state and working registers
    t_state        r_state, n_state;
    logic          r_issued, n_issued;
    logic          r_ov, n_ov;
    logic [31:0]   r_ft, n_ft;
    logic [1:0]    r_kind, n_kind;
    logic [19:0]   r_raw, n_raw;
    logic [63:0]   r_a, n_a;
    logic [63:0]   r_b, n_b;
    logic [63:0]   r_c, n_c;
    logic [63:0]   r_d, n_d;
    logic [31:0]   r_res, n_res;
    logic [1:0]    r_st, n_st;
    sce_pkg::t_out r_out, n_out;

    // shared units
    logic          w_mul_start;
    logic          w_mul_done;
    logic [63:0]   w_ma;
    logic [63:0]   w_mb;
    logic [63:0]   w_mp;
    logic          w_div_start;
    logic          w_div_done;
    logic [63:0]   w_quo;
    logic          w_in_mul;

    // calibration fields
    logic [15:0]   w_t1;
    logic [31:0]   w_t2;
    logic [31:0]   w_t3;
    logic [63:0]   w_p1, w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;
    logic [31:0]   w_h1, w_h2, w_h3, w_h4, w_h5, w_h6;

    // derived values
    logic [31:0]   w_d1;
    logic [31:0]   w_d2;
    logic [31:0]   w_t5;
    logic [63:0]   w_pv1;
    logic [63:0]   w_pp;
    logic [63:0]   w_hi;
    logic [31:0]   w_hv;
    logic [31:0]   w_hcl;
    logic [31:0]   w_hsh;

    always_comb begin
        w_t1 = r_cal_t[15:0];
        w_t2 = {{16{r_cal_t[31]}}, r_cal_t[31:16]};
        w_t3 = {{16{r_cal_t[47]}}, r_cal_t[47:32]};
        w_p1 = {48'b0, r_cal_pa[15:0]};
        w_p2 = {{48{r_cal_pa[31]}}, r_cal_pa[31:16]};
        w_p3 = {{48{r_cal_pa[47]}}, r_cal_pa[47:32]};
        w_p4 = {{48{r_cal_pb[15]}}, r_cal_pb[15:0]};
        w_p5 = {{48{r_cal_pb[31]}}, r_cal_pb[31:16]};
        w_p6 = {{48{r_cal_pb[47]}}, r_cal_pb[47:32]};
        w_p7 = {{48{r_cal_pc[15]}}, r_cal_pc[15:0]};
        w_p8 = {{48{r_cal_pc[31]}}, r_cal_pc[31:16]};
        w_p9 = {{48{r_cal_pc[47]}}, r_cal_pc[47:32]};
        w_h1 = {24'b0, r_cal_h[7:0]};
        w_h2 = {{16{r_cal_h[23]}}, r_cal_h[23:8]};
        w_h3 = {24'b0, r_cal_h[31:24]};
        w_h4 = {{20{r_cal_h[43]}}, r_cal_h[43:32]};
        w_h5 = {{20{r_cal_h[55]}}, r_cal_h[55:44]};
        w_h6 = {{24{r_cal_h[63]}}, r_cal_h[63:56]};

        w_d1  = {15'b0, r_raw[19:3]} - {15'b0, w_t1, 1'b0};
        w_d2  = {16'b0, r_raw[19:4]} - {16'b0, w_t1};
        w_t5  = {r_ft[29:0], 2'b0} + r_ft + sce_pkg::C_T_ROUND;
        w_pv1 = {{32{r_ft[31]}}, r_ft} - sce_pkg::C_P_FINE_OFS;
        w_pp  = sce_pkg::C_P_BASE - {44'b0, r_raw};
        w_hi  = sce_pkg::f_asr64(r_a, 6'd13);
        w_hv  = r_ft - sce_pkg::C_H_FINE_OFS;

        // humidity clamp to 0..max, scale, zero substitute
        if (r_a[31]) begin
            w_hcl = 32'd0;
        end else if (r_a[31:0] > sce_pkg::C_H_MAX) begin
            w_hcl = sce_pkg::C_H_MAX;
        end else begin
            w_hcl = r_a[31:0];
        end
        w_hsh = (w_hcl >> 12);
        if (w_hsh == 32'd0) begin
            w_hsh = sce_pkg::C_H_ZERO_SUB;
        end
    end

    // multiplier operand select by step
    always_comb begin
        w_in_mul = 1'b1;
        w_ma     = 64'd0;
        w_mb     = 64'd0;
        case (r_state)
            S_T_M1: begin
                w_ma = {32'b0, w_d1};
                w_mb = {32'b0, w_t2};
            end
            S_T_M2: begin
                w_ma = {32'b0, w_d2};
                w_mb = {32'b0, w_d2};
            end
            S_T_M3: begin
                w_ma = {32'b0, r_b[31:0]};
                w_mb = {32'b0, w_t3};
            end
            S_P_M1: begin
                w_ma = w_pv1;
                w_mb = w_pv1;
            end
            S_P_M2: begin
                w_ma = r_a;
                w_mb = w_p6;
            end
            S_P_M3: begin
                w_ma = w_pv1;
                w_mb = w_p5;
            end
            S_P_M4: begin
                w_ma = r_a;
                w_mb = w_p3;
            end
            S_P_M5: begin
                w_ma = w_pv1;
                w_mb = w_p2;
            end
            S_P_M6: begin
                w_ma = r_c + sce_pkg::C_P_ONE47;
                w_mb = w_p1;
            end
            S_P_M7: begin
                w_ma = {w_pp[32:0], 31'b0} - r_b;
                w_mb = sce_pkg::C_P_SCALE;
            end
            S_P_M8: begin
                w_ma = w_p9;
                w_mb = w_hi;
            end
            S_P_M9: begin
                w_ma = r_b;
                w_mb = w_hi;
            end
            S_P_M10: begin
                w_ma = w_p8;
                w_mb = r_a;
            end
            S_H_M1: begin
                w_ma = {32'b0, w_h5};
                w_mb = {32'b0, w_hv};
            end
            S_H_M2: begin
                w_ma = {32'b0, w_hv};
                w_mb = {32'b0, w_h6};
            end
            S_H_M3: begin
                w_ma = {32'b0, w_hv};
                w_mb = {32'b0, w_h3};
            end
            S_H_M4: begin
                w_ma = {32'b0, r_b[31:0]};
                w_mb = {32'b0, r_c[31:0]};
            end
            S_H_M5: begin
                w_ma = {32'b0, r_c[31:0]};
                w_mb = {32'b0, w_h2};
            end
            S_H_M6: begin
                w_ma = {32'b0, r_a[31:0]};
                w_mb = {32'b0, r_c[31:0]};
            end
            S_H_M7: begin
                w_ma = {32'b0, r_b[31:0]};
                w_mb = {32'b0, r_b[31:0]};
            end
            S_H_M8: begin
                w_ma = {32'b0, r_c[31:0]};
                w_mb = {32'b0, w_h1};
            end
            default: begin
                w_in_mul = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_issued = r_issued;
        n_ov     = r_ov;
        n_ft     = r_ft;
        n_kind   = r_kind;
        n_raw    = r_raw;
        n_a      = r_a;
        n_b      = r_b;
        n_c      = r_c;
        n_d      = r_d;
        n_res    = r_res;
        n_st     = r_st;
        n_out    = r_out;

        w_mul_start = 1'b0;
        w_div_start = 1'b0;

        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end

        // issue to the shared units once per step
        if (w_in_mul && !r_issued) begin
            w_mul_start = 1'b1;
            n_issued    = 1'b1;
        end
        if ((r_state == S_P_DIV) && !r_issued) begin
            w_div_start = 1'b1;
            n_issued    = 1'b1;
        end
        if (w_mul_done || w_div_done) begin
            n_issued = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_kind = i_in.cmd;
                    n_raw  = i_in.raw_value;
                    n_res  = 32'd0;
                    n_st   = sce_pkg::ST_OK;
                    case (i_in.cmd)
                        sce_pkg::KIND_TEMP:  n_state = S_T_M1;
                        sce_pkg::KIND_PRESS: n_state = S_P_M1;
                        sce_pkg::KIND_HUM:   n_state = S_H_M1;
                        default:             n_state = S_FIN;
                    endcase
                end
            end

            // temperature
            S_T_M1: begin
                if (w_mul_done) begin
                    n_a     = {32'b0, sce_pkg::f_asr32(w_mp[31:0], 6'd11)};
                    n_state = S_T_M2;
                end
            end
            S_T_M2: begin
                if (w_mul_done) begin
                    n_b     = {32'b0, sce_pkg::f_asr32(w_mp[31:0], 6'd12)};
                    n_state = S_T_M3;
                end
            end
            S_T_M3: begin
                if (w_mul_done) begin
                    n_ft    = r_a[31:0] + sce_pkg::f_asr32(w_mp[31:0], 6'd14);
                    n_state = S_T_RES;
                end
            end
            S_T_RES: begin
                n_res   = sce_pkg::f_asr32(w_t5, 6'd8);
                n_state = S_FIN;
            end

            // pressure
            S_P_M1: begin
                if (w_mul_done) begin
                    n_a     = w_mp;
                    n_state = S_P_M2;
                end
            end
            S_P_M2: begin
                if (w_mul_done) begin
                    n_b     = w_mp;
                    n_state = S_P_M3;
                end
            end
            S_P_M3: begin
                if (w_mul_done) begin
                    n_b     = r_b + {w_mp[46:0], 17'b0} + {w_p4[28:0], 35'b0};
                    n_state = S_P_M4;
                end
            end
            S_P_M4: begin
                if (w_mul_done) begin
                    n_c     = sce_pkg::f_asr64(w_mp, 6'd8);
                    n_state = S_P_M5;
                end
            end
            S_P_M5: begin
                if (w_mul_done) begin
                    n_c     = r_c + {w_mp[51:0], 12'b0};
                    n_state = S_P_M6;
                end
            end
            S_P_M6: begin
                if (w_mul_done) begin
                    n_d     = sce_pkg::f_asr64(w_mp, 6'd33);
                    n_state = S_P_CHK;
                end
            end
            S_P_CHK: begin
                if (r_d == 64'd0) begin
                    n_res   = 32'd0;
                    n_st    = sce_pkg::ST_DIV0;
                    n_state = S_FIN;
                end else begin
                    n_state = S_P_M7;
                end
            end
            S_P_M7: begin
                if (w_mul_done) begin
                    n_a     = w_mp;
                    n_state = S_P_DIV;
                end
            end
            S_P_DIV: begin
                if (w_div_done) begin
                    n_a     = w_quo;
                    n_state = S_P_M8;
                end
            end
            S_P_M8: begin
                if (w_mul_done) begin
                    n_b     = w_mp;
                    n_state = S_P_M9;
                end
            end
            S_P_M9: begin
                if (w_mul_done) begin
                    n_c     = sce_pkg::f_asr64(w_mp, 6'd25);
                    n_state = S_P_M10;
                end
            end
            S_P_M10: begin
                if (w_mul_done) begin
                    n_b     = sce_pkg::f_asr64(w_mp, 6'd19);
                    n_state = S_P_SUM;
                end
            end
            S_P_SUM: begin
                n_d     = sce_pkg::f_asr64(r_a + r_c + r_b, 6'd8) + {w_p7[59:0], 4'b0};
                n_state = S_P_SAT;
            end
            S_P_SAT: begin
                // saturate to the signed 32-bit range
                if (!r_d[63] && (|r_d[62:31])) begin
                    n_res = 32'h7FFF_FFFF;
                    n_st  = sce_pkg::ST_SAT;
                end else if (r_d[63] && !(&r_d[62:31])) begin
                    n_res = 32'h8000_0000;
                    n_st  = sce_pkg::ST_SAT;
                end else begin
                    n_res = r_d[31:0];
                    n_st  = sce_pkg::ST_OK;
                end
                n_state = S_FIN;
            end

            // humidity
            S_H_M1: begin
                if (w_mul_done) begin
                    n_a = {32'b0, sce_pkg::f_asr32({2'b0, r_raw[15:0], 14'b0}
                              - {w_h4[11:0], 20'b0} - w_mp[31:0]
                              + sce_pkg::C_H_ROUND_T, 6'd15)};
                    n_state = S_H_M2;
                end
            end
            S_H_M2: begin
                if (w_mul_done) begin
                    n_b     = {32'b0, sce_pkg::f_asr32(w_mp[31:0], 6'd10)};
                    n_state = S_H_M3;
                end
            end
            S_H_M3: begin
                if (w_mul_done) begin
                    n_c     = {32'b0, sce_pkg::f_asr32(w_mp[31:0], 6'd11)
                               + sce_pkg::C_H_Y_OFS};
                    n_state = S_H_M4;
                end
            end
            S_H_M4: begin
                if (w_mul_done) begin
                    n_c     = {32'b0, sce_pkg::f_asr32(w_mp[31:0], 6'd10)
                               + sce_pkg::C_H_Z_OFS};
                    n_state = S_H_M5;
                end
            end
            S_H_M5: begin
                if (w_mul_done) begin
                    n_c     = {32'b0, sce_pkg::f_asr32(w_mp[31:0]
                               + sce_pkg::C_H_ROUND_Z, 6'd14)};
                    n_state = S_H_M6;
                end
            end
            S_H_M6: begin
                if (w_mul_done) begin
                    n_d     = {32'b0, w_mp[31:0]};
                    n_b     = {32'b0, sce_pkg::f_asr32(w_mp[31:0], 6'd15)};
                    n_state = S_H_M7;
                end
            end
            S_H_M7: begin
                if (w_mul_done) begin
                    n_c     = {32'b0, sce_pkg::f_asr32(w_mp[31:0], 6'd7)};
                    n_state = S_H_M8;
                end
            end
            S_H_M8: begin
                if (w_mul_done) begin
                    n_a     = {32'b0, r_d[31:0] - sce_pkg::f_asr32(w_mp[31:0], 6'd4)};
                    n_state = S_H_CLAMP;
                end
            end
            S_H_CLAMP: begin
                n_res   = w_hsh;
                n_state = S_FIN;
            end

            // hand the result to the output register
            S_FIN: begin
                if (!r_ov || i_out_ready) begin
                    n_ov                 = 1'b1;
                    n_out.result_value   = r_res;
                    n_out.result_kind    = r_kind;
                    n_out.status         = r_st;
                    n_state              = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_ov     <= 1'b0;
            r_ft     <= 32'd0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
            r_ov     <= n_ov;
            r_ft     <= n_ft;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_raw  <= n_raw;
        r_a    <= n_a;
        r_b    <= n_b;
        r_c    <= n_c;
        r_d    <= n_d;
        r_res  <= n_res;
        r_st   <= n_st;
        r_out  <= n_out;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_t  <= 48'd0;
            r_cal_pa <= 48'd0;
            r_cal_pb <= 48'd0;
            r_cal_pc <= 48'd0;
            r_cal_h  <= 64'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sce_pkg::REG_TEMP_CAL: r_cal_t  <= i_cfg_data[47:0];
                sce_pkg::REG_PRESS_A:  r_cal_pa <= i_cfg_data[47:0];
                sce_pkg::REG_PRESS_B:  r_cal_pb <= i_cfg_data[47:0];
                sce_pkg::REG_PRESS_C:  r_cal_pc <= i_cfg_data[47:0];
                sce_pkg::REG_HUM_CAL:  r_cal_h  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    sce_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mul_done),
        .o_prod  (w_mp)
    );

    sce_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_a),
        .i_den   (r_d),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    // checks
    `SCE_ASSERT_NXT(a_busy_after_transfer, i_in_valid && o_in_ready, !o_in_ready, "ready after input transfer")
    `SCE_ASSERT_IMP(a_mul_done_in_step, w_mul_done, w_in_mul, "product outside multiply step")
    `SCE_ASSERT_IMP(a_div_done_in_step, w_div_done, r_state == S_P_DIV, "quotient outside divide step")
    `SCE_ASSERT_IMP(a_status_kind, o_out_valid && (o_out.status != sce_pkg::ST_OK), o_out.result_kind == sce_pkg::KIND_PRESS, "error status on non-pressure result")

endmodule
